### hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/chs_pkg.sv
`default_nettype none

package chs_pkg;

    // width of the divide datapath
    localparam int DQ_W = 32;

    // request opcodes
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_PEEK  = 2'd3
    } t_cmd;

    // register indexes on the config port
    typedef enum logic [1:0] {
        REG_RANGE_MIN = 2'd0,
        REG_RANGE_MAX = 2'd1,
        REG_NUM_BINS  = 2'd2,
        REG_BIN_WIDTH = 2'd3
    } t_reg_idx;

    // config reset values
    localparam logic [31:0] RST_RANGE_MIN = 32'd0;
    localparam logic [31:0] RST_RANGE_MAX = 32'd65536;
    localparam logic [6:0]  RST_NUM_BINS  = 7'd16;
    localparam logic [30:0] RST_BIN_WIDTH = 31'd4096;

    // saturation limits
    localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;
    localparam logic [63:0] SUM_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_NEG_MAX = 64'h8000_0000_0000_0000;
    localparam logic [31:0] AVG_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] AVG_NEG_MAX = 32'h8000_0000;

    // shared subtract unit operations
    typedef enum logic {
        ALU_CMP  = 1'b0,
        ALU_STEP = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [DQ_W-1:0]   rem;
        logic [DQ_W-1:0]   dq;
        logic [DQ_W-1:0]   divisor;
    } t_alu_req;

    typedef struct packed {
        logic              ge;
        logic [DQ_W-1:0]   rem;
        logic [DQ_W-1:0]   dq;
    } t_alu_rsp;

endpackage

`default_nettype wire

### hdl/chs_ram.sv
`default_nettype none

module chs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/chs_alu.sv
`default_nettype none

module chs_alu (
    input  wire chs_pkg::t_alu_req i_req,
    output chs_pkg::t_alu_rsp      o_rsp
);
    import chs_pkg::*;

    logic [DQ_W:0]   opa;
    logic [DQ_W+1:0] diff;

    // compare uses the remainder as is, a divide step shifts in the next dividend bit
    assign opa  = (i_req.op == ALU_STEP) ? {i_req.rem, i_req.dq[DQ_W-1]}
                                         : {1'b0, i_req.rem};
    assign diff = {1'b0, opa} - {2'b00, i_req.divisor};

    // restoring step: keep the difference when it does not go negative
    assign o_rsp.ge  = ~diff[DQ_W+1];
    assign o_rsp.rem = o_rsp.ge ? diff[DQ_W-1:0] : opa[DQ_W-1:0];
    assign o_rsp.dq  = {i_req.dq[DQ_W-2:0], o_rsp.ge};

endmodule

`default_nettype wire

### hdl/clamped_histogram_with_stats.sv
`default_nettype none
`include "assert_macros.svh"

// Histogram of signed Q16.16 samples with per-bin count and average.
// Request channel: drive cmd, sample and bin_index with start high; the
// request is taken at a clock edge where start is high and busy is low.
// Busy stays high until the result has been shown.
// Result channel: o_strobe is high for exactly one cycle with all result
// fields valid; the receiver cannot stall, so it must take them then.
// Config: APB-style writes at byte address 4*index, pready always high;
// write only while busy is low.
// From accept to strobe, an add runs the one shared subtract unit through
// a compare plus log2(MAX_BINS) steps for the bin index; an add or a
// query of a nonempty bin then runs a compare plus 32 restoring steps for
// the average. Saturated cases skip the steps, an empty bin skips the
// average and a clear uses neither. The next request can be taken in the
// cycle after the strobe.
// Reset: config goes to range 0..1.0, 16 bins of width 1/16, all bins read
// as empty, min/max are seeded from the range, total is zero.

module clamped_histogram_with_stats #(
    parameter int MAX_BINS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [31:0] i_sample,
    input  wire logic [5:0]         i_bin_index,
    // result channel
    output logic                    o_strobe,
    output logic [5:0]              o_bin_hit,
    output logic [31:0]             o_bin_count,
    output logic signed [31:0]      o_bin_average,
    output logic signed [31:0]      o_running_min,
    output logic signed [31:0]      o_running_max,
    output logic [31:0]             o_total_count,
    // config port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import chs_pkg::*;

    localparam int IDX_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int LO_SHIFT = DQ_W - IDX_W;
    localparam int MEM_W    = 96;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_BCMP = 10'b00_0000_0010,
        ST_BDIV = 10'b00_0000_0100,
        ST_READ = 10'b00_0000_1000,
        ST_UPD  = 10'b00_0001_0000,
        ST_AVG0 = 10'b00_0010_0000,
        ST_ACMP = 10'b00_0100_0000,
        ST_ADIV = 10'b00_1000_0000,
        ST_AFIN = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } t_state;

    t_state                r_state;
    logic signed [31:0]    r_range_min;
    logic signed [31:0]    r_range_max;
    logic [6:0]            r_num_bins;
    logic [30:0]           r_bin_width;
    logic signed [31:0]    r_min;
    logic signed [31:0]    r_max;
    logic [31:0]           r_total;
    logic [MAX_BINS-1:0]   r_valid;

    t_cmd                  r_cmd;
    logic [31:0]           r_sample;
    logic                  r_oob;
    logic [IDX_W-1:0]      r_addr;
    logic [5:0]            r_hit;
    logic [31:0]           r_cnt;
    logic [63:0]           r_sum;
    logic [31:0]           r_avg;
    logic [DQ_W-1:0]       r_rem;
    logic [DQ_W-1:0]       r_dq;
    logic [DQ_W-1:0]       r_div;
    logic                  r_neg;
    logic [5:0]            r_iter;

    logic                  accept;
    logic                  cfg_we;
    t_cmd                  in_cmd;
    logic [31:0]           width_eff;
    logic [IDX_W-1:0]      last_bin;
    logic [32:0]           diff_raw;
    logic [32:0]           diff_pos;
    logic [DQ_W-1:0]       div_hi;
    logic [DQ_W-1:0]       div_lo;
    logic [IDX_W-1:0]      quo_bin;
    logic [IDX_W-1:0]      n_addr;
    t_alu_req              alu_req;
    t_alu_rsp              alu_rsp;
    logic                  mem_we;
    logic [MEM_W-1:0]      mem_wdata;
    logic [MEM_W-1:0]      mem_rdata;
    logic                  rd_hit;
    logic [31:0]           rd_cnt;
    logic [63:0]           rd_sum;
    logic [31:0]           cnt_inc;
    logic [63:0]           samp_ext;
    logic [63:0]           sum_add;
    logic                  sum_ovf;
    logic [63:0]           sum_sat;
    logic [63:0]           sum_mag;
    logic [31:0]           avg_sat;

    assign accept = start && !busy;
    assign cfg_we = psel && penable && pwrite && pready;
    assign in_cmd = t_cmd'(i_cmd);

    // effective bin width and last bin in use
    assign width_eff = (r_bin_width == '0) ? 32'd1 : {1'b0, r_bin_width};

    always_comb begin
        if (r_num_bins == '0) begin
            last_bin = '0;
        end else if (32'(r_num_bins) > MAX_BINS) begin
            last_bin = IDX_W'(MAX_BINS - 1);
        end else begin
            last_bin = IDX_W'(r_num_bins - 7'd1);
        end
    end

    // offset into the range, negative offsets go to bin 0
    assign diff_raw = {i_sample[31], i_sample} - {r_range_min[31], r_range_min};
    assign diff_pos = diff_raw[32] ? 33'd0 : diff_raw;
    assign div_hi   = DQ_W'(diff_pos >> IDX_W);
    assign div_lo   = DQ_W'(diff_pos[IDX_W-1:0]) << LO_SHIFT;

    // clamp the bin quotient
    assign quo_bin = alu_rsp.dq[IDX_W-1:0];
    assign n_addr  = (quo_bin > last_bin) ? last_bin : quo_bin;

    // shared subtract unit
    assign alu_req.op      = ((r_state == ST_BCMP) || (r_state == ST_ACMP)) ? ALU_CMP
                                                                            : ALU_STEP;
    assign alu_req.rem     = r_rem;
    assign alu_req.dq      = r_dq;
    assign alu_req.divisor = r_div;

    chs_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // bin store: {sum, count}
    chs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // a bin not written since clear reads as empty
    assign rd_hit = r_valid[r_addr] && !r_oob;
    assign rd_cnt = rd_hit ? mem_rdata[31:0] : 32'd0;
    assign rd_sum = rd_hit ? mem_rdata[95:32] : 64'd0;

    // saturating count and sum update
    assign cnt_inc  = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
    assign samp_ext = {{32{r_sample[31]}}, r_sample};
    assign sum_add  = rd_sum + samp_ext;
    assign sum_ovf  = (rd_sum[63] == samp_ext[63]) && (sum_add[63] != rd_sum[63]);
    assign sum_sat  = sum_ovf ? (samp_ext[63] ? SUM_NEG_MAX : SUM_POS_MAX) : sum_add;

    assign mem_we    = (r_state == ST_UPD) && (r_cmd == CMD_ADD);
    assign mem_wdata = {sum_sat, cnt_inc};

    // magnitude of the sum for the average
    assign sum_mag = r_sum[63] ? (64'd0 - r_sum) : r_sum;

    // signed and saturated average from the quotient
    always_comb begin
        if (r_neg) begin
            avg_sat = (r_dq > AVG_NEG_MAX) ? AVG_NEG_MAX : (32'd0 - r_dq);
        end else begin
            avg_sat = (r_dq > AVG_POS_MAX) ? AVG_POS_MAX : r_dq;
        end
    end

    // sequencer, config and running stats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_range_min <= RST_RANGE_MIN;
            r_range_max <= RST_RANGE_MAX;
            r_num_bins  <= RST_NUM_BINS;
            r_bin_width <= RST_BIN_WIDTH;
            r_min       <= RST_RANGE_MAX;
            r_max       <= RST_RANGE_MIN;
            r_total     <= '0;
        end else begin
            if (cfg_we) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_RANGE_MIN: r_range_min <= pwdata;
                    REG_RANGE_MAX: r_range_max <= pwdata;
                    REG_NUM_BINS:  r_num_bins  <= pwdata[6:0];
                    REG_BIN_WIDTH: r_bin_width <= pwdata[30:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (in_cmd)
                            CMD_ADD: begin
                                r_state <= ST_BCMP;
                                if (i_sample > r_max) r_max <= i_sample;
                                if (i_sample < r_min) r_min <= i_sample;
                                if (r_total != CNT_MAX) r_total <= r_total + 32'd1;
                            end
                            CMD_CLEAR: begin
                                r_state <= ST_OUT;
                                r_min   <= r_range_max;
                                r_max   <= r_range_min;
                                r_total <= '0;
                            end
                            default: begin
                                r_state <= ST_READ;
                            end
                        endcase
                    end
                end
                ST_BCMP: r_state <= alu_rsp.ge ? ST_READ : ST_BDIV;
                ST_BDIV: if (r_iter == '0) r_state <= ST_READ;
                ST_READ: r_state <= ST_UPD;
                ST_UPD:  r_state <= ST_AVG0;
                ST_AVG0: r_state <= (r_cnt == '0) ? ST_OUT : ST_ACMP;
                ST_ACMP: r_state <= alu_rsp.ge ? ST_OUT : ST_ADIV;
                ST_ADIV: if (r_iter == '0) r_state <= ST_AFIN;
                ST_AFIN: r_state <= ST_OUT;
                ST_OUT:  r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // per-bin valid bits, cleared at once by reset and by a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (accept && (in_cmd == CMD_CLEAR)) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_cmd    <= in_cmd;
                    r_sample <= i_sample;
                    case (in_cmd)
                        CMD_ADD: begin
                            r_oob <= 1'b0;
                            r_rem <= div_hi;
                            r_dq  <= div_lo;
                            r_div <= width_eff;
                        end
                        CMD_CLEAR: begin
                            r_hit <= '0;
                            r_cnt <= '0;
                            r_avg <= '0;
                        end
                        default: begin
                            r_hit  <= i_bin_index;
                            r_oob  <= (32'(i_bin_index) >= MAX_BINS);
                            r_addr <= IDX_W'(i_bin_index);
                        end
                    endcase
                end
            end
            ST_BCMP: begin
                if (alu_rsp.ge) begin
                    r_addr <= last_bin;
                end else begin
                    r_iter <= 6'(IDX_W - 1);
                end
            end
            ST_BDIV: begin
                r_rem  <= alu_rsp.rem;
                r_dq   <= alu_rsp.dq;
                r_iter <= r_iter - 6'd1;
                if (r_iter == '0) r_addr <= n_addr;
            end
            ST_READ: begin
                if (r_cmd == CMD_ADD) r_hit <= 6'(r_addr);
            end
            ST_UPD: begin
                if (r_cmd == CMD_ADD) begin
                    r_cnt <= cnt_inc;
                    r_sum <= sum_sat;
                end else begin
                    r_cnt <= rd_cnt;
                    r_sum <= rd_sum;
                end
            end
            ST_AVG0: begin
                if (r_cnt == '0) begin
                    r_avg <= '0;
                end else begin
                    r_rem <= sum_mag[63:32];
                    r_dq  <= sum_mag[31:0];
                    r_div <= r_cnt;
                    r_neg <= r_sum[63];
                end
            end
            ST_ACMP: begin
                if (alu_rsp.ge) begin
                    r_avg <= r_neg ? AVG_NEG_MAX : AVG_POS_MAX;
                end else begin
                    r_iter <= 6'(DQ_W - 1);
                end
            end
            ST_ADIV: begin
                r_rem  <= alu_rsp.rem;
                r_dq   <= alu_rsp.dq;
                r_iter <= r_iter - 6'd1;
            end
            ST_AFIN: r_avg <= avg_sat;
            default: ;
        endcase
    end

    // config readback
    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_RANGE_MIN: prdata = r_range_min;
            REG_RANGE_MAX: prdata = r_range_max;
            REG_NUM_BINS:  prdata = {25'd0, r_num_bins};
            REG_BIN_WIDTH: prdata = {1'b0, r_bin_width};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // outputs
    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = (r_state == ST_OUT);
    assign o_bin_hit     = r_hit;
    assign o_bin_count   = r_cnt;
    assign o_bin_average = r_avg;
    assign o_running_min = r_min;
    assign o_running_max = r_max;
    assign o_total_count = r_total;

    // checks
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request taken but not busy")
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_strobe, !busy, "not idle after result")
    `ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n,
                 (r_state == ST_BDIV) || (r_state == ST_ADIV), r_rem < r_div,
                 "divide remainder not below divisor")
    `ASSERT_IMPL(a_empty_avg, i_clk, i_rst_n,
                 o_strobe && (o_bin_count == 32'd0), o_bin_average == 32'sd0,
                 "empty bin with nonzero average")

endmodule

`default_nettype wire
